/* src/assert_macros.svh */
// Assertion macros for the RTL of the waveform renderer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/wcr_pkg.sv */
// Types and constants shared by the waveform column renderer modules.
package wcr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FPC    = 2'd0;
  localparam logic [1:0] CFG_COLS   = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [15:0] FPC_RESET    = 16'd16;
  localparam logic [11:0] COLS_RESET   = 12'd400;
  localparam logic [6:0]  HEIGHT_RESET = 7'd64;

  localparam logic signed [15:0] MIN_INIT = 16'sh7FFF;
  localparam logic signed [15:0] MAX_INIT = 16'sh8000;
  localparam logic [7:0]         PIX_FULL = 8'd255;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRE,
    ST_POST,
    ST_EMIT
  } wcr_state_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               new_image;
  } wcr_in_t;

  typedef struct packed {
    logic [7:0]  pixel_value;
    logic [5:0]  row_index;
    logic [11:0] column_index;
    logic        column_last;
  } wcr_out_t;

  // A row on its way along the span cells, collecting the miss count.
  typedef struct packed {
    logic        valid;
    logic [5:0]  row;
    logic [11:0] column;
    logic        last;
    logic [4:0]  miss;
  } wcr_tok_t;

  // Level write into one span cell when a span closes.
  typedef struct packed {
    logic       en;
    logic [3:0] span;
    logic [5:0] low;
    logic [5:0] high;
  } wcr_lvl_wr_t;

endpackage

/* src/wcr_span_cell.sv */
// One span cell: holds a span's level range and adds its miss to a passing row.
module wcr_span_cell import wcr_pkg::*; #(
  parameter int LVL_W   = 6,
  parameter int SPAN_ID = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  wcr_lvl_wr_t wr_i,
  input  wcr_tok_t    tok_i,
  output wcr_tok_t    tok_o
);

  logic [LVL_W-1:0] low_q;
  logic [LVL_W-1:0] high_q;
  wcr_tok_t         tok_q;
  wcr_tok_t         tok_d;
  logic             miss;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.span == 4'(SPAN_ID))) begin
      low_q  <= wr_i.low[LVL_W-1:0];
      high_q <= wr_i.high[LVL_W-1:0];
    end
  end

  assign miss = (tok_i.row < 6'(low_q)) || (tok_i.row > 6'(high_q));

  always_comb begin
    tok_d      = tok_i;
    tok_d.miss = tok_i.miss + 5'(miss);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (adv_i) begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* src/wcr_cell_chain.sv */
// Row of span cells; a row enters at cell zero and leaves with its miss count.
module wcr_cell_chain import wcr_pkg::*; #(
  parameter int SUBSAMPLES = 16,
  parameter int LVL_W      = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  wcr_lvl_wr_t wr_i,
  input  wcr_tok_t    tok_i,
  output wcr_tok_t    tok_o,
  output logic        busy_o
);

  wcr_tok_t                tok_w [SUBSAMPLES+1];
  logic [SUBSAMPLES-1:0]   valid_w;

  assign tok_w[0] = tok_i;

  for (genvar i = 0; i < SUBSAMPLES; i++) begin : g_cell
    wcr_span_cell #(
      .LVL_W   (LVL_W),
      .SPAN_ID (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv_i),
      .wr_i   (wr_i),
      .tok_i  (tok_w[i]),
      .tok_o  (tok_w[i+1])
    );
    assign valid_w[i] = tok_w[i+1].valid;
  end

  assign tok_o  = tok_w[SUBSAMPLES];
  assign busy_o = |valid_w;

endmodule

/* src/waveform_column_renderer.sv */
// Waveform column renderer: span min/max tracking and per-row pixel output.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | input     | in_valid_i/in_stall_o | wcr_in_t  (sample, new_image)
//  out     | output    | out_valid_o/out_stall_i | wcr_out_t (pixel, row, column)
//  cfg     | input     | cfg_valid_i/cfg_ready_o | index and 16-bit write data
//
// A frame passes through the idle, pre and post states; pre and post repeat
// while span boundaries close. A column's last frame then feeds its image rows
// to the span cells, one row per cycle unless the output stalls; the next beat
// is taken once the last row has left the SUBSAMPLES cells.
// Reset puts every counter back at once; the span levels need no clearing.
// An output stall freezes the cell chain, so rows still in the cells hold off
// the input; a pixel waiting alone in the output register does not.
`include "assert_macros.svh"

module waveform_column_renderer import wcr_pkg::*; #(
  parameter int SUBSAMPLES = 16,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  wcr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output wcr_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int SPAN_W = $clog2(SUBSAMPLES);
  localparam int SPC_W  = $clog2(SUBSAMPLES + 1);
  localparam int SUM_W  = 16 + $clog2(SUBSAMPLES);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int LVL_W  = $clog2(MAX_HEIGHT);
  localparam int STEP   = 255 / SUBSAMPLES;

  // Configuration.
  logic [15:0] fpc_q;
  logic [11:0] cols_q;
  logic [6:0]  height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpc_q    <= FPC_RESET;
      cols_q   <= COLS_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FPC:    fpc_q    <= cfg_data_i;
        CFG_COLS:   cols_q   <= cfg_data_i[11:0];
        CFG_HEIGHT: height_q <= cfg_data_i[6:0];
        default:    ;
      endcase
    end
  end

  logic [15:0]   k_eff;
  logic [HW-1:0] h_eff;

  assign k_eff = (fpc_q == 16'd0) ? 16'd1 : fpc_q;
  assign h_eff = (height_q > 7'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : height_q[HW-1:0];

  // Column tracking state.
  wcr_state_e         state_q, state_d;
  logic [15:0]        pos_q, pos_d;
  logic [SPC_W-1:0]   span_q, span_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [11:0]        col_q, col_d;
  logic signed [15:0] min_q, min_d;
  logic signed [15:0] max_q, max_d;
  logic signed [15:0] smp_q, smp_d;
  logic [HW-1:0]      row_q, row_d;

  logic        adv;
  logic        accept;
  logic        chain_busy;
  wcr_tok_t    feed;
  wcr_tok_t    tail;
  wcr_lvl_wr_t lvl_wr;

  assign in_stall_o = !((state_q == ST_IDLE) && !chain_busy);
  assign accept     = in_valid_i && !in_stall_o;
  assign adv        = !out_valid_o || !out_stall_i;

  // Values after an optional restart by new_image.
  logic               ni;
  logic [15:0]        pos_e;
  logic [SPC_W-1:0]   span_e;
  logic [11:0]        col_e;
  logic signed [15:0] min_e, max_e;
  logic [SUM_W-1:0]   sum_e;
  logic               ignore;

  assign ni     = in_data_i.new_image;
  assign pos_e  = ni ? 16'd0 : pos_q;
  assign span_e = ni ? '0 : span_q;
  assign col_e  = ni ? 12'd0 : col_q;
  assign min_e  = ni ? MIN_INIT : min_q;
  assign max_e  = ni ? MAX_INIT : max_q;
  assign sum_e  = ((pos_e == 16'd0) && (span_e == '0)) ? SUM_W'(k_eff) : sum_q;
  assign ignore = col_e >= cols_q;

  // A span ends at floor(sum / SUBSAMPLES); pos >= that end exactly when
  // pos * SUBSAMPLES + SUBSAMPLES - 1 >= sum.
  logic [SUM_W:0] bound;
  logic           close_cond;

  assign bound = (SUM_W+1)'(pos_q) * (SUM_W+1)'(SUBSAMPLES) + (SUM_W+1)'(SUBSAMPLES - 1);
  assign close_cond = (span_q < SPC_W'(SUBSAMPLES)) && (bound >= {1'b0, sum_q});

  // Row levels floor(h * (x + 32768) / 65536) of the closing span.
  logic [15:0]      off_min, off_max;
  logic [HW+15:0]   prod_min, prod_max;
  logic [LVL_W-1:0] lvl_low, lvl_high;

  assign off_min  = {~min_q[15], min_q[14:0]};
  assign off_max  = {~max_q[15], max_q[14:0]};
  assign prod_min = (HW+16)'(h_eff) * (HW+16)'(off_min);
  assign prod_max = (HW+16)'(h_eff) * (HW+16)'(off_max);
  assign lvl_low  = prod_min[16 +: LVL_W];
  assign lvl_high = prod_max[16 +: LVL_W];

  logic column_done;
  logic last_row;

  assign column_done = (span_q == SPC_W'(SUBSAMPLES));
  assign last_row    = (row_q == HW'(h_eff - 1'b1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && !ignore) state_d = ST_PRE;
      end
      ST_PRE: begin
        if (!close_cond) state_d = ST_POST;
      end
      ST_POST: begin
        if (!close_cond) begin
          if (column_done && (h_eff != '0)) state_d = ST_EMIT;
          else                              state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (adv && last_row) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath updates, level writes and row feed.
  always_comb begin
    pos_d  = pos_q;
    span_d = span_q;
    sum_d  = sum_q;
    col_d  = col_q;
    min_d  = min_q;
    max_d  = max_q;
    smp_d  = smp_q;
    row_d  = row_q;

    lvl_wr      = '0;
    lvl_wr.span = 4'(span_q[SPAN_W-1:0]);
    lvl_wr.low  = 6'(lvl_low);
    lvl_wr.high = 6'(lvl_high);

    feed        = '0;
    feed.row    = 6'(row_q);
    feed.column = col_q;
    feed.last   = last_row;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d  = pos_e;
          span_d = span_e;
          col_d  = col_e;
          min_d  = min_e;
          max_d  = max_e;
          sum_d  = sum_e;
          smp_d  = in_data_i.sample;
        end
      end
      ST_PRE, ST_POST: begin
        if (close_cond) begin
          lvl_wr.en = 1'b1;
          min_d     = MIN_INIT;
          max_d     = MAX_INIT;
          span_d    = span_q + 1'b1;
          sum_d     = sum_q + SUM_W'(k_eff);
        end else if (state_q == ST_PRE) begin
          if (smp_q < min_q) min_d = smp_q;
          if (smp_q > max_q) max_d = smp_q;
          pos_d = pos_q + 16'd1;
        end else if (column_done) begin
          row_d = '0;
          // With zero rows the column still counts but shows nothing.
          if (h_eff == '0) begin
            col_d  = col_q + 12'd1;
            min_d  = MIN_INIT;
            max_d  = MAX_INIT;
            pos_d  = 16'd0;
            span_d = '0;
            sum_d  = SUM_W'(k_eff);
          end
        end
      end
      ST_EMIT: begin
        if (adv) begin
          feed.valid = 1'b1;
          row_d      = row_q + 1'b1;
          if (last_row) begin
            col_d  = col_q + 12'd1;
            min_d  = MIN_INIT;
            max_d  = MAX_INIT;
            pos_d  = 16'd0;
            span_d = '0;
            sum_d  = SUM_W'(k_eff);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= 16'd0;
      span_q  <= '0;
      sum_q   <= SUM_W'(FPC_RESET);
      col_q   <= 12'd0;
      min_q   <= MIN_INIT;
      max_q   <= MAX_INIT;
      row_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      span_q  <= span_d;
      sum_q   <= sum_d;
      col_q   <= col_d;
      min_q   <= min_d;
      max_q   <= max_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  wcr_cell_chain #(
    .SUBSAMPLES (SUBSAMPLES),
    .LVL_W      (LVL_W)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .wr_i   (lvl_wr),
    .tok_i  (feed),
    .tok_o  (tail),
    .busy_o (chain_busy)
  );

  // Output register.
  logic        out_valid_q;
  wcr_out_t    out_q, out_d;
  logic [12:0] drop;

  assign drop = 13'(STEP) * 13'(tail.miss);

  always_comb begin
    out_d.pixel_value  = 8'(13'(PIX_FULL) - drop);
    out_d.row_index    = tail.row;
    out_d.column_index = tail.column;
    out_d.column_last  = tail.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic last_feed;
  logic restarted;

  assign last_feed = feed.valid && feed.last;
  assign restarted = (state_q == ST_IDLE) && (span_q == '0) && (pos_q == 16'd0);

  // Span levels must never change under rows still in flight.
  `ASSERT_ALWAYS(a_wr_idle_chain, clk_i, rst_ni, !(lvl_wr.en && chain_busy), "level write in flight")
  // Rows are fed only once every span of the column has closed.
  `ASSERT_ALWAYS(a_feed_done, clk_i, rst_ni, !feed.valid || column_done, "row fed early")
  // The final row restarts the column tracking.
  `ASSERT_NEXT(a_last_restart, clk_i, rst_ni, last_feed, restarted, "column not restarted")

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the waveform column renderer: directed cases and random traffic.
module tb_top;
  import wcr_pkg::*;

  localparam int         SPANS          = 16;
  localparam int         ROW_LIMIT      = 64;
  localparam logic [1:0] CFG_UNMAPPED   = 2'd3;
  localparam int         SETTLE_CYCLES  = 100;
  localparam int         END_WAIT_LIMIT = 20000;
  localparam int         CYCLE_LIMIT    = 3000000;
  localparam int         REPORT_LIMIT   = 10;
  localparam int         RANDOM_PHASES  = 6;
  localparam int         PHASE_FRAMES   = 48;
  localparam int         HOLD_CYCLES    = 600;
  localparam int         FULL_FPC       = 65535;
  localparam int         LARGE_FRAMES   = 24;

  localparam logic signed [15:0] CORNER_SAMPLES [8] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
    16'sh0001, 16'sh4000, 16'shC000, 16'sh0200
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  wcr_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  wcr_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_FPC;
  logic [15:0] cfg_data_i  = '0;

  waveform_column_renderer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the block: registers, span tracking and column position.
  logic [15:0]        fpc_q;
  logic [11:0]        cols_q;
  logic [6:0]         height_q;
  logic signed [15:0] span_min;
  logic signed [15:0] span_max;
  logic [5:0]         level_lo [SPANS];
  logic [5:0]         level_hi [SPANS];
  logic [15:0]        frame_pos;
  int unsigned        span_idx;
  logic [19:0]        bound_sum;
  logic [11:0]        column_q;

  wcr_out_t    pending_pixels [$];
  int          mismatches     = 0;
  int          frames_rendered = 0;
  int          send_gap_max   = 6;
  int          recv_gap_max   = 6;
  int          hold_cycles    = 0;
  int          wave_center    = 0;
  int unsigned cycle_count    = 0;

  function automatic logic [19:0] frames_eff();
    return (fpc_q == '0) ? 20'd1 : 20'(fpc_q);
  endfunction

  function automatic int unsigned rows_eff();
    return (height_q > 7'(ROW_LIMIT)) ? ROW_LIMIT : int'(height_q);
  endfunction

  function automatic logic [5:0] row_level(logic signed [15:0] x);
    int unsigned off;
    off = int'(x) + 32768;
    return 6'((rows_eff() * off) >> 16);
  endfunction

  function automatic void restart_spans();
    span_min  = MIN_INIT;
    span_max  = MAX_INIT;
    frame_pos = '0;
    span_idx  = 0;
    bound_sum = frames_eff();
  endfunction

  // A span ends at (span_idx + 1) * k / SPANS; several may end on one frame when k is small.
  function automatic void close_spans();
    while (span_idx < SPANS && 32'(frame_pos) >= 32'(bound_sum) / SPANS) begin
      level_lo[span_idx] = row_level(span_min);
      level_hi[span_idx] = row_level(span_max);
      span_min  = MIN_INIT;
      span_max  = MAX_INIT;
      span_idx++;
      bound_sum = bound_sum + frames_eff();
    end
  endfunction

  function automatic void emit_pixels();
    int unsigned miss;
    wcr_out_t    px;
    for (int unsigned r = 0; r < rows_eff(); r++) begin
      miss = 0;
      for (int s = 0; s < SPANS; s++) begin
        if (r < level_lo[s] || level_hi[s] < r) miss++;
      end
      px.pixel_value  = PIX_FULL - 8'(miss * (int'(PIX_FULL) / SPANS));
      px.row_index    = 6'(r);
      px.column_index = column_q;
      px.column_last  = (r + 1 == rows_eff());
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic void render_frame(wcr_in_t frame);
    logic signed [15:0] x;
    x = frame.sample;
    if (frame.new_image) begin
      column_q = '0;
      restart_spans();
    end
    if (column_q >= cols_q) return;
    frames_rendered++;
    if (frame_pos == '0 && span_idx == 0) bound_sum = frames_eff();
    close_spans();
    if (x < span_min) span_min = x;
    if (x > span_max) span_max = x;
    frame_pos = frame_pos + 16'd1;
    close_spans();
    if (span_idx >= SPANS) begin
      emit_pixels();
      column_q = column_q + 12'd1;
      restart_spans();
    end
  endfunction

  function automatic void reset_model();
    fpc_q    = FPC_RESET;
    cols_q   = COLS_RESET;
    height_q = HEIGHT_RESET;
    for (int s = 0; s < SPANS; s++) begin
      level_lo[s] = '0;
      level_hi[s] = '0;
    end
    column_q = '0;
    restart_spans();
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      CFG_FPC:    fpc_q    = val;
      CFG_COLS:   cols_q   = val[11:0];
      CFG_HEIGHT: height_q = val[6:0];
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] audio_sample();
    int          v;
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return 16'($urandom);
    if (pick < 9) begin
      v = wave_center + int'($urandom_range(2047)) - 1024;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return 16'(v);
    end
    return CORNER_SAMPLES[$urandom_range(3)];
  endfunction

  // Valid stays high from one beat to the next unless a gap is drawn.
  task automatic send_frame(input logic signed [15:0] smp, input logic restart);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= '{sample: smp, new_image: restart};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    render_frame(in_data_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves valid high so that writes can follow back to back; the caller lowers it.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, val);
  endtask

  task automatic configure(input logic [15:0] fpc, input logic [15:0] cols,
                           input logic [15:0] rows);
    settle();
    write_reg(CFG_FPC, fpc);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_HEIGHT, rows);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_values();
    for (int i = 0; i < SPANS; i++) begin
      send_frame(i < 8 ? CORNER_SAMPLES[i] : audio_sample(), i == 0);
    end
  endtask

  // Fewer frames than spans leaves empty spans; with one row they cover it.
  task automatic test_short_columns();
    configure(16'd0, 16'd400, 16'd1);
    send_frame(16'sh7FFF, 1'b0);
    configure(16'd0, 16'd400, 16'd64);
    send_frame(16'sh8000, 1'b0);
    configure(16'd3, 16'd400, 16'd64);
    for (int i = 0; i < 3; i++) send_frame(audio_sample(), 1'b0);
  endtask

  task automatic test_height_limits();
    configure(16'd0, 16'd400, 16'd0);
    send_frame(16'sh1234, 1'b0);
    configure(16'd0, 16'd400, 16'd127);
    send_frame(16'shEDCB, 1'b0);
  endtask

  task automatic test_unmapped_register();
    settle();
    write_reg(CFG_UNMAPPED, 16'($urandom));
    cfg_valid_i <= 1'b0;
    send_frame(audio_sample(), 1'b0);
  endtask

  // The column count drops below the current column, then to zero, then to its top.
  task automatic test_column_limit();
    configure(16'd0, 16'd1, 16'd64);
    send_frame(16'sh0100, 1'b0);
    send_frame(16'shFF00, 1'b1);
    send_frame(16'sh0100, 1'b0);
    configure(16'd0, 16'd0, 16'd64);
    send_frame(16'sh2000, 1'b1);
    configure(16'd0, 16'd4095, 16'd8);
    send_frame(16'shE000, 1'b1);
  endtask

  task automatic test_backpressure();
    configure(16'd16, 16'd4095, 16'd64);
    send_gap_max = 0;
    hold_cycles  = HOLD_CYCLES;
    for (int i = 0; i < 3 * SPANS; i++) send_frame(audio_sample(), i == 0);
    // Sender waits here for every pixel before it goes on.
    settle();
    send_gap_max = 6;
    for (int i = 0; i < SPANS; i++) send_frame(audio_sample(), 1'b0);
  endtask

  task automatic test_random_traffic();
    int          target;
    int unsigned pick;
    logic [15:0] fpc;
    logic [11:0] cols;
    logic [6:0]  rows;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      pick = $urandom_range(9);
      fpc  = (pick < 6) ? 16'($urandom_range(40, 16)) :
             (pick < 8) ? 16'($urandom_range(15, 0)) :
             (pick < 9) ? 16'($urandom_range(300, 41)) : 16'd16;
      cols = ($urandom_range(4) == 0) ? 12'd4095 : 12'($urandom_range(12, 1));
      pick = $urandom_range(9);
      rows = (pick < 7) ? 7'($urandom_range(64, 1)) :
             (pick < 8) ? 7'd0 :
             (pick < 9) ? 7'($urandom_range(127, 65)) : 7'd64;
      // Upper bits of the narrower registers carry junk that must be dropped.
      configure(fpc, {4'($urandom), cols}, {9'($urandom), rows});
      send_gap_max = $urandom_range(1) * 6;
      recv_gap_max = $urandom_range(1) * 6;
      target = frames_rendered + PHASE_FRAMES;
      while (frames_rendered < target) begin
        if ($urandom_range(15) == 0) wave_center = int'($urandom_range(65535)) - 32768;
        if (column_q >= cols_q) send_frame(audio_sample(), $urandom_range(2) == 0);
        else send_frame(audio_sample(), $urandom_range(49) == 0);
      end
    end
    send_gap_max = 6;
    recv_gap_max = 6;
  endtask

  // A few frames at the largest frame count; the first span is still open afterwards.
  task automatic test_largest_column();
    configure(16'(FULL_FPC), 16'd4095, 16'd64);
    send_gap_max = 0;
    recv_gap_max = 0;
    for (int i = 0; i < LARGE_FRAMES; i++) send_frame(audio_sample(), i == 0);
    send_gap_max = 6;
    recv_gap_max = 6;
  endtask

  // Receiver: a random wait after each beat, or a long hold when one is requested.
  initial begin
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        wait_left   = hold_cycles;
        hold_cycles = 0;
      end else if (out_valid_o && !out_stall_i) begin
        wait_left = $urandom_range(recv_gap_max, 0);
      end else if (wait_left > 0) begin
        wait_left--;
      end
      out_stall_i <= (wait_left > 0);
    end
  end

  always @(posedge clk_i) begin
    wcr_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected pixel: value %0d row %0d column %0d last %0b",
                   out_data_o.pixel_value, out_data_o.row_index,
                   out_data_o.column_index, out_data_o.column_last);
      end else begin
        want = pending_pixels.pop_front();
        if (want.pixel_value !== out_data_o.pixel_value ||
            want.row_index !== out_data_o.row_index ||
            want.column_index !== out_data_o.column_index ||
            want.column_last !== out_data_o.column_last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("pixel mismatch at %0t: expected value %0d row %0d column %0d last %0b",
                     $time, want.pixel_value, want.row_index, want.column_index,
                     want.column_last);
            $display("  actual value %0d row %0d column %0d last %0b",
                     out_data_o.pixel_value, out_data_o.row_index,
                     out_data_o.column_index, out_data_o.column_last);
          end
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int end_wait;
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_short_columns();
    test_height_limits();
    test_unmapped_register();
    test_column_limit();
    test_backpressure();
    test_random_traffic();
    test_largest_column();
    in_valid_i <= 1'b0;
    end_wait = 0;
    while (pending_pixels.size() != 0 && end_wait < END_WAIT_LIMIT) begin
      @(posedge clk_i);
      end_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    mismatches += pending_pixels.size();
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
